// ===== design/hsc_pkg.sv =====
// shared types, constants and elaboration-time helpers for the hamming codec
package hsc_pkg;

	localparam int WORD_W = 38;
	localparam int SYN_W  = 6;

	typedef enum logic {
		REQ_ENCODE = 1'b0,
		REQ_DECODE = 1'b1
	} req_type_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [SYN_W-1:0]  syndrome;
		logic              corrected;
		logic              bad_syndrome;
	} hsc_result_t;

	// true for positions 1, 2, 4, ...
	function automatic logic is_pow2(input int p);
		return (p != 0) && ((p & (p - 1)) == 0);
	endfunction

	// least r with m + r + 1 <= 2^r
	function automatic int parity_count(input int m);
		int r;
		r = 0;
		for (int i = 0; i < 32; i++) begin
			if (m + r + 1 > (1 << r)) begin
				r++;
			end
		end
		return r;
	endfunction

	// 1-based codeword position of data bit k (k = 0 is the first data bit)
	function automatic int data_pos(input int k);
		int cnt;
		int pos;
		cnt = 0;
		pos = 0;
		for (int p = 1; p <= 128; p++) begin
			if (!is_pow2(p)) begin
				if (cnt == k && pos == 0) begin
					pos = p;
				end
				cnt++;
			end
		end
		return pos;
	endfunction

endpackage

// ===== design/hsc_encoder.sv =====
// hamming encoder: data word to codeword with even parity at power-of-two positions
module hsc_encoder
	import hsc_pkg::*;
#(
	parameter int DATA_BYTES = 4
) (
	input  logic [WORD_W-1:0] data_in,
	output logic [WORD_W-1:0] code_out
);

	localparam int M = 8 * DATA_BYTES;
	localparam int R = parity_count(M);
	localparam int N = M + R;

	logic [M-1:0] data;
	logic [N-1:0] cw;
	logic [R-1:0] par;

	// bits above the word port read as zero
	always_comb begin
		data = '0;
		for (int i = 0; i < M; i++) begin
			if (i < WORD_W) begin
				data[i] = data_in[i];
			end
		end
	end

	// data bits into non-parity positions, parity as xor of their positions
	always_comb begin
		cw  = '0;
		par = '0;
		for (int k = 0; k < M; k++) begin
			cw[N - data_pos(k)] = data[M-1-k];
			if (data[M-1-k]) begin
				par = par ^ R'(data_pos(k));
			end
		end
		for (int j = 0; j < R; j++) begin
			cw[N - (1 << j)] = par[j];
		end
	end

	always_comb begin
		code_out = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (i < N) begin
				code_out[i] = cw[i];
			end
		end
	end

endmodule

// ===== design/hsc_decoder.sv =====
// hamming decoder: syndrome, single-bit correction and data extraction
module hsc_decoder
	import hsc_pkg::*;
#(
	parameter int DATA_BYTES = 4
) (
	input  logic [WORD_W-1:0] code_in,
	output hsc_result_t       result
);

	localparam int M = 8 * DATA_BYTES;
	localparam int R = parity_count(M);
	localparam int N = M + R;
	localparam logic [R-1:0] N_POS = R'(N);

	logic [N-1:0] cw;
	logic [N-1:0] fixed;
	logic [M-1:0] data;
	logic [R-1:0] syn;
	logic         in_range;
	logic         do_flip;

	always_comb begin
		cw = '0;
		for (int i = 0; i < N; i++) begin
			if (i < WORD_W) begin
				cw[i] = code_in[i];
			end
		end
	end

	// syndrome: xor of the positions of all one bits
	always_comb begin
		syn = '0;
		for (int p = 1; p <= N; p++) begin
			if (cw[N-p]) begin
				syn = syn ^ R'(p);
			end
		end
	end

	assign in_range = (syn <= N_POS);
	assign do_flip  = (syn != '0) && in_range;

	always_comb begin
		for (int p = 1; p <= N; p++) begin
			fixed[N-p] = cw[N-p] ^ (do_flip && (syn == R'(p)));
		end
	end

	always_comb begin
		for (int k = 0; k < M; k++) begin
			data[M-1-k] = fixed[N - data_pos(k)];
		end
	end

	always_comb begin
		result = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (i < M) begin
				result.word[i] = data[i];
			end
		end
		result.syndrome     = SYN_W'(syn);
		result.corrected    = do_flip;
		result.bad_syndrome = (syn != '0) && !in_range;
	end

endmodule

// ===== design/hamming_sec_codec.sv =====
// hamming single-error-correcting codec top level: input stage, codec logic, result stage
// a request accepted into the input stage register moves on to the result stage register, which drives out_valid
// throughput: one request per cycle; the input stage and result stage both advance
//   whenever the result stage is empty or its result is being taken
// a result that waits on out_ready leaves room for one more request in the input stage,
//   after which the input stalls until the result is taken
// reset: arst_n clears both stage valid flags asynchronously; payload registers are not reset
module hamming_sec_codec
	import hsc_pkg::*;
#(
	parameter int DATA_BYTES = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	input  logic [WORD_W-1:0] word_in,
	// result channel
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WORD_W-1:0] word_out,
	output logic [SYN_W-1:0]  syndrome,
	output logic              corrected,
	output logic              bad_syndrome
);

	localparam int M = 8 * DATA_BYTES;
	localparam int N = M + parity_count(M);

	// stage 1: registered request
	logic              valid_s1;
	req_type_t         req_type_s1;
	logic [WORD_W-1:0] word_s1;

	// stage 2: registered result
	logic              valid_s2;
	hsc_result_t       result_s2;

	logic              load_s2;
	logic [WORD_W-1:0] enc_word;
	hsc_result_t       dec_result;
	hsc_result_t       result;

	// result stage takes a new result when empty or draining this cycle
	assign load_s2  = valid_s1 && (!valid_s2 || out_ready);
	// input stage is free when empty or moving on
	assign in_ready = !valid_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_type_s1 <= req_type_t'(req_type);
			word_s1     <= word_in;
		end
	end

	hsc_encoder #(
		.DATA_BYTES(DATA_BYTES)
	) u_encoder (
		.data_in (word_s1),
		.code_out(enc_word)
	);

	hsc_decoder #(
		.DATA_BYTES(DATA_BYTES)
	) u_decoder (
		.code_in(word_s1),
		.result (dec_result)
	);

	// encode reports no syndrome or flags
	always_comb begin
		result = '0;
		unique case (req_type_s1)
			REQ_ENCODE: begin
				result.word = enc_word;
			end
			REQ_DECODE: begin
				result = dec_result;
			end
			default: begin
				result = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			result_s2 <= result;
		end
	end

	assign out_valid    = valid_s2;
	assign word_out     = result_s2.word;
	assign syndrome     = result_s2.syndrome;
	assign corrected    = result_s2.corrected;
	assign bad_syndrome = result_s2.bad_syndrome;

	// a flip and an out-of-range syndrome exclude each other
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(corrected && bad_syndrome))
		else $error("corrected and bad_syndrome both set");

	// a correction names a real position
	a_corrected_has_syndrome: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && corrected) |-> (syndrome != '0) && (int'(syndrome) <= N))
		else $error("correction without a valid syndrome");

	// out-of-range flag only beyond the codeword length
	a_bad_beyond_length: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bad_syndrome) |-> (int'(syndrome) > N))
		else $error("bad_syndrome with syndrome inside the codeword");

	// an accepted request occupies the input stage next cycle
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted request lost from input stage");

	// a request in stage 1 with a free result stage moves on
	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !valid_s2) |=> valid_s2)
		else $error("result stage did not take a pending result");

endmodule

// ===== tb/tb_hamming_sec_codec.sv =====
// self-checking testbench for the hamming single-error-correcting codec
`timescale 1ns / 100ps

module tb_hamming_sec_codec;
	import hsc_pkg::*;

	localparam int DATA_BYTES = 4;

	// code geometry worked out independently of the design
	function automatic int check_bits_for(input int m);
		int r;
		r = 0;
		while ((1 << r) < m + r + 1) begin
			r++;
		end
		return r;
	endfunction

	localparam int DATA_W = 8 * DATA_BYTES;
	localparam int CHK_W  = check_bits_for(DATA_W);
	localparam int CW_LEN = DATA_W + CHK_W;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	req_type_t         req_type;
	logic [WORD_W-1:0] word_in;
	logic              out_valid;
	logic              out_ready;
	logic [WORD_W-1:0] word_out;
	logic [SYN_W-1:0]  syndrome;
	logic              corrected;
	logic              bad_syndrome;

	hamming_sec_codec #(
		.DATA_BYTES(DATA_BYTES)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.word_in     (word_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.word_out    (word_out),
		.syndrome    (syndrome),
		.corrected   (corrected),
		.bad_syndrome(bad_syndrome)
	);

	// results still owed by the codec, oldest first
	hsc_result_t pending_codec_results[$];

	int error_count;
	int send_idle_pct;
	int recv_idle_pct;
	int recv_hold_cycles;
	int n_encode_reqs;
	int n_decode_reqs;
	int n_corrections;
	int n_bad_syndromes;
	int n_input_stalls;

	// 10 ns clock
	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	// hard stop well beyond the slowest legitimate run
	initial begin
		#5_000_000;
		$display("timeout with %0d results still outstanding", pending_codec_results.size());
		$display("Test completed with failures");
		$finish;
	end

	// bit-accurate prediction of one codec request
	function automatic hsc_result_t compute_hamming_result(input req_type_t rt,
		input logic [WORD_W-1:0] w);
		logic [63:0] src;
		logic [63:0] cw;
		logic [63:0] dat;
		int          syn;
		int          k;
		hsc_result_t res;
		src = 64'(w);
		cw  = '0;
		dat = '0;
		syn = 0;
		k   = 0;
		res = '0;
		if (rt == REQ_ENCODE) begin
			// data bits fill the non power-of-two positions, first data bit first
			for (int p = 1; p <= CW_LEN; p++) begin
				if ($countones(p) != 1) begin
					if (src[DATA_W-1-k]) begin
						cw[CW_LEN-p] = 1'b1;
						syn ^= p;
					end
					k++;
				end
			end
			// check bit 2^j makes the parity over its group even
			for (int j = 0; j < CHK_W; j++) begin
				if ((syn >> j) & 1) begin
					cw[CW_LEN-(1<<j)] = 1'b1;
				end
			end
			res.word = cw[WORD_W-1:0];
		end else begin
			// bits above the codeword are dropped
			cw = (CW_LEN >= 64) ? src : (src & ((64'd1 << CW_LEN) - 64'd1));
			for (int p = 1; p <= CW_LEN; p++) begin
				if (cw[CW_LEN-p]) begin
					syn ^= p;
				end
			end
			if (syn != 0) begin
				if (syn <= CW_LEN) begin
					cw[CW_LEN-syn] = ~cw[CW_LEN-syn];
					res.corrected = 1'b1;
				end else begin
					// out of range: flag it, leave the codeword alone
					res.bad_syndrome = 1'b1;
				end
			end
			for (int p = 1; p <= CW_LEN; p++) begin
				if ($countones(p) != 1) begin
					dat = {dat[62:0], cw[CW_LEN-p]};
				end
			end
			res.word     = dat[WORD_W-1:0];
			res.syndrome = SYN_W'(syn);
		end
		return res;
	endfunction

	function automatic logic [WORD_W-1:0] encode_data(input logic [WORD_W-1:0] d);
		hsc_result_t r;
		r = compute_hamming_result(REQ_ENCODE, d);
		return r.word;
	endfunction

	// invert the bit at 1-based codeword position p
	function automatic logic [WORD_W-1:0] flip_position(input logic [WORD_W-1:0] w,
		input int p);
		return w ^ (WORD_W'(1) << (CW_LEN - p));
	endfunction

	function automatic logic [WORD_W-1:0] random_word();
		return WORD_W'({$urandom(), $urandom()});
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		error_count++;
	endtask

	// drive one request at the falling edge and hold it until the codec takes it
	task automatic send_request(input req_type_t rt, input logic [WORD_W-1:0] w);
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do begin
				@(negedge clk);
			end while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		word_in  <= w;
		@(posedge clk);
		while (!in_ready) begin
			n_input_stalls++;
			@(posedge clk);
		end
		// accepted at this edge: queue the predicted result
		pending_codec_results = {pending_codec_results, compute_hamming_result(rt, w)};
		if (rt == REQ_ENCODE) begin
			n_encode_reqs++;
		end else begin
			n_decode_reqs++;
		end
	endtask

	task automatic release_request_channel();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// sender sits idle until every owed result has come back
	task automatic wait_results_drained();
		release_request_channel();
		while (pending_codec_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// receiver: random stalls, or a counted hold-off when one is requested
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (recv_hold_cycles > 0) begin
				out_ready <= 1'b0;
				recv_hold_cycles--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// result checker: each taken result against the oldest prediction
	always @(posedge clk) begin
		hsc_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_codec_results.size() == 0) begin
				report_mismatch("result with no request outstanding", 64'(word_out), 64'd0);
			end else begin
				want = pending_codec_results.pop_front();
				if (word_out !== want.word) begin
					report_mismatch("word_out", 64'(word_out), 64'(want.word));
				end
				if (syndrome !== want.syndrome) begin
					report_mismatch("syndrome", 64'(syndrome), 64'(want.syndrome));
				end
				if (corrected !== want.corrected) begin
					report_mismatch("corrected", 64'(corrected), 64'(want.corrected));
				end
				if (bad_syndrome !== want.bad_syndrome) begin
					report_mismatch("bad_syndrome", 64'(bad_syndrome),
						64'(want.bad_syndrome));
				end
				if (want.corrected) begin
					n_corrections++;
				end
				if (want.bad_syndrome) begin
					n_bad_syndromes++;
				end
			end
		end
	end

	// encode corners: empty, full, single end bits, junk above the data field
	task automatic test_encode_extremes();
		send_request(REQ_ENCODE, '0);
		send_request(REQ_ENCODE, '1);
		send_request(REQ_ENCODE, WORD_W'((64'd1 << DATA_W) - 64'd1));
		send_request(REQ_ENCODE, WORD_W'(64'd1 << (DATA_W - 1)));
		send_request(REQ_ENCODE, WORD_W'(1));
		// only the ignored high bits set, must encode as all zero
		send_request(REQ_ENCODE, ~WORD_W'((64'd1 << DATA_W) - 64'd1));
		send_request(REQ_ENCODE, WORD_W'(64'hAAAA_AAAA_AAAA));
		send_request(REQ_ENCODE, WORD_W'(64'h5555_5555_5555));
	endtask

	// decode corners: clean words, single errors at the ends, syndrome range edges
	task automatic test_decode_corners();
		logic [WORD_W-1:0] cw;
		cw = encode_data(WORD_W'(32'hDEAD_BEEF));
		send_request(REQ_DECODE, '0);
		send_request(REQ_DECODE, '1);
		send_request(REQ_DECODE, cw);
		// single errors on a check bit, a data bit and the last position
		send_request(REQ_DECODE, flip_position(cw, 1));
		send_request(REQ_DECODE, flip_position(cw, 3));
		send_request(REQ_DECODE, flip_position(cw, CW_LEN));
		// two errors whose syndrome lands exactly on the last position
		send_request(REQ_DECODE, flip_position(flip_position(cw, 32), 6));
		// syndrome just past the codeword and at the top of its range
		send_request(REQ_DECODE, flip_position(flip_position(cw, 32), 7));
		send_request(REQ_DECODE, flip_position(flip_position(cw, 33), 30));
		send_request(REQ_DECODE, flip_position(flip_position('0, 32), 31));
	endtask

	// mixed encodes and decodes of clean, single-error and double-error codewords with random payload, some noise
	task automatic test_random_traffic(input int count);
		logic [WORD_W-1:0] cw;
		int                kind;
		int                p1;
		int                p2;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(99);
			cw   = encode_data(random_word());
			p1   = $urandom_range(CW_LEN, 1);
			p2   = $urandom_range(CW_LEN, 1);
			if (p2 == p1) begin
				p2 = (p1 == CW_LEN) ? 1 : p1 + 1;
			end
			if (kind < 30) begin
				send_request(REQ_ENCODE, random_word());
			end else if (kind < 45) begin
				send_request(REQ_DECODE, cw);
			end else if (kind < 75) begin
				send_request(REQ_DECODE, flip_position(cw, p1));
			end else if (kind < 90) begin
				// double error: miscorrects or lands outside the codeword
				send_request(REQ_DECODE, flip_position(flip_position(cw, p1), p2));
			end else begin
				send_request(req_type_t'($urandom_range(1)), random_word());
			end
		end
	endtask

	// receiver holds off while the sender keeps offering, so the input backs up
	task automatic test_output_backpressure();
		int saved_send;
		int saved_recv;
		wait_results_drained();
		saved_send       = send_idle_pct;
		saved_recv       = recv_idle_pct;
		send_idle_pct    = 0;
		recv_idle_pct    = 0;
		recv_hold_cycles = 60;
		test_random_traffic(24);
		wait_results_drained();
		send_idle_pct = saved_send;
		recv_idle_pct = saved_recv;
	endtask

	// bursts separated by a full drain of the codec
	task automatic test_drain_between_bursts();
		test_random_traffic(12);
		wait_results_drained();
		test_random_traffic(12);
		wait_results_drained();
	endtask

	initial begin
		error_count      = 0;
		n_encode_reqs    = 0;
		n_decode_reqs    = 0;
		n_corrections    = 0;
		n_bad_syndromes  = 0;
		n_input_stalls   = 0;
		recv_hold_cycles = 0;
		send_idle_pct    = 0;
		recv_idle_pct    = 0;
		arst_n           = 1'b0;
		in_valid         = 1'b0;
		req_type         = REQ_ENCODE;
		word_in          = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// light sender idling, heavy receiver stalls
		send_idle_pct = 19;
		recv_idle_pct = 79;
		test_encode_extremes();
		test_decode_corners();
		test_random_traffic(440);
		test_output_backpressure();

		// heavy sender idling, light receiver stalls
		send_idle_pct = 79;
		recv_idle_pct = 19;
		test_drain_between_bursts();
		test_random_traffic(430);

		// back to back on both sides
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(430);

		wait_results_drained();
		// quiet tail with the receiver open to catch anything spurious
		repeat (8) @(posedge clk);

		$display("checked %0d encode and %0d decode requests", n_encode_reqs, n_decode_reqs);
		$display("%0d single-bit fixes, %0d out-of-range syndromes, %0d input stall cycles",
			n_corrections, n_bad_syndromes, n_input_stalls);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
